/* rtl/core/shs_pkg.sv */
package shs_pkg;

  localparam int SLOTS  = 64;
  localparam int BINS   = 64;
  localparam int SLOT_W = 6;
  localparam int BIN_W  = 6;
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_AW  = $clog2(SLOTS * BINS);

  localparam int VAL_W   = 48;
  localparam int WID_W   = 47;
  localparam int NBIN_W  = 7;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 64;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 48;

  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_DIST = 2'd0,
    MODE_AVG  = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_MIN  = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_RESULT_MODE = 3'd0,
    REG_RANGE_MIN   = 3'd1,
    REG_RANGE_MAX   = 3'd2,
    REG_BIN_WIDTH   = 3'd3,
    REG_BINS_IN_USE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [VAL_W-1:0]  range_min;
    logic signed [VAL_W-1:0]  range_max;
    logic [WID_W-1:0]         bin_width;
    logic [BIN_W-1:0]         last_bin;
  } cfg_t;

  localparam logic [VAL_W-1:0]  RST_RANGE_MIN = 48'd0;
  localparam logic [VAL_W-1:0]  RST_RANGE_MAX = 48'd65536;
  localparam logic [WID_W-1:0]  RST_BIN_WIDTH = 47'd6554;
  localparam logic [NBIN_W-1:0] RST_BINS      = 7'd10;

  function automatic logic [BIN_W-1:0] last_bin_f(logic [NBIN_W-1:0] n);
    logic [BIN_W-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (n > NBIN_W'(BINS)) begin
      r = BIN_W'(BINS - 1);
    end else begin
      r = BIN_W'(n - NBIN_W'(1));
    end
    return r;
  endfunction

endpackage

/* rtl/core/shs_if.sv */
interface shs_in_if;
  import shs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] sample_value;
  logic [SLOT_W-1:0]       time_slot;
  logic [BIN_W-1:0]        read_bin;

  modport source (output valid, cmd, sample_value, time_slot, read_bin, input ready);
  modport sink (input valid, cmd, sample_value, time_slot, read_bin, output ready);
endinterface

interface shs_out_if;
  import shs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [BIN_W-1:0]        bin_hit;
  logic                    sample_taken;
  logic [CNT_W-1:0]        bin_count_out;
  logic signed [SUM_W-1:0] slot_value_out;

  modport source (output valid, bin_hit, sample_taken, bin_count_out, slot_value_out,
                  input ready);
  modport sink (input valid, bin_hit, sample_taken, bin_count_out, slot_value_out,
                output ready);
endinterface

interface shs_cfg_if;
  import shs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/shs_cfg_regs.sv */
module shs_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  shs_cfg_if.sink         cfg_i,
  output shs_pkg::cfg_t   cfg_o
);
  import shs_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_DIST;
      cfg_q.range_min <= RST_RANGE_MIN;
      cfg_q.range_max <= RST_RANGE_MAX;
      cfg_q.bin_width <= RST_BIN_WIDTH;
      cfg_q.last_bin  <= last_bin_f(RST_BINS);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RESULT_MODE: cfg_q.mode      <= mode_e'(cfg_i.data[MODE_W-1:0]);
        REG_RANGE_MIN:   cfg_q.range_min <= cfg_i.data[VAL_W-1:0];
        REG_RANGE_MAX:   cfg_q.range_max <= cfg_i.data[VAL_W-1:0];
        REG_BIN_WIDTH:   cfg_q.bin_width <= cfg_i.data[WID_W-1:0];
        REG_BINS_IN_USE: cfg_q.last_bin  <= last_bin_f(cfg_i.data[NBIN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/shs_div.sv */
module shs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [shs_pkg::VAL_W-1:0] dividend_i,
  input  logic [shs_pkg::WID_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [shs_pkg::VAL_W-1:0] quotient_o
);
  import shs_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [VAL_W-1:0]  dvd_q;
  logic [WID_W-1:0]  dsr_q;
  logic [WID_W-1:0]  rem_q;
  logic [VAL_W-1:0]  trial;
  logic [VAL_W-1:0]  diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[VAL_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_STEPS);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? diff[WID_W-1:0] : trial[WID_W-1:0];
        dvd_q <= {dvd_q[VAL_W-2:0], ge};
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < dsr_q) else $error("divider remainder not below divisor");

endmodule

/* rtl/core/slotted_histogram_stats_unit.sv */
// Slotted histogram statistics unit.
// in_i carries transactions of cmd, sample_value (signed Q31.16), time_slot and read_bin.
// An add updates one slot in the mode of result_mode: distribution bins the sample,
// average adds it to a saturating sum, maximum and minimum keep the extreme.
// A read returns the count of one bin and the value of one slot.
// out_o carries one result transaction per input transaction, in order.
// cfg_i writes the five registers by index; write only while the unit is idle.
// A read or a non-distribution add passes through the read request, modify and done
// states before out_o valid; a distribution add first checks the range and, unless the
// bin width is zero, waits on the radix-2 divider, which produces one quotient bit per
// cycle over 48 steps. An ignored add goes straight to the done state.
// One transaction is in work at a time; in_i.ready is high only while idle.
// After reset the unit sweeps both stores to zero, one count entry per cycle, over all
// 4096 entries, with in_i.ready low; configuration writes are taken meanwhile.
// A result waits in an output register while out_o.ready is low; the next transaction
// may be accepted then, and its result holds until the output register frees up.
module slotted_histogram_stats_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  shs_in_if.sink    in_i,
  shs_out_if.source out_o,
  shs_cfg_if.sink   cfg_i
);
  import shs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RANGE,
    S_DIV,
    S_RDREQ,
    S_MODIFY,
    S_DONE
  } state_e;

  state_e                  state_q;
  logic [CNT_AW-1:0]       clr_q;
  logic                    cmd_q;
  logic signed [VAL_W-1:0] smp_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [BIN_W-1:0]        rbin_q;
  logic                    slot_ok_q;
  logic                    rbin_ok_q;
  logic [BIN_W-1:0]        bin_q;
  logic [CNT_AW-1:0]       addr_q;

  logic [BIN_W-1:0]        res_hit_q;
  logic                    res_taken_q;
  logic [CNT_W-1:0]        res_cnt_q;
  logic signed [SUM_W-1:0] res_val_q;

  logic                    out_valid_q;
  logic [BIN_W-1:0]        out_hit_q;
  logic                    out_taken_q;
  logic [CNT_W-1:0]        out_cnt_q;
  logic signed [SUM_W-1:0] out_val_q;

  logic [CNT_W-1:0]        cnt_mem [SLOTS*BINS];
  logic signed [SUM_W-1:0] val_mem [SLOTS];
  logic [CNT_W-1:0]        rd_cnt_q;
  logic signed [SUM_W-1:0] rd_val_q;

  cfg_t                    cfg;
  logic                    div_start;
  logic                    div_done;
  logic [VAL_W-1:0]        quot;
  logic [VAL_W-1:0]        diff;
  logic                    out_of_range;
  logic [BIN_W-1:0]        q_bin;

  logic                    cnt_we;
  logic [CNT_AW-1:0]       cnt_waddr;
  logic [CNT_W-1:0]        cnt_wdata;
  logic                    val_we;
  logic [SLOT_AW-1:0]      val_waddr;
  logic signed [SUM_W-1:0] val_wdata;

  logic [CNT_W-1:0]        cnt_inc;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic signed [SUM_W-1:0] smp_ext;
  logic                    first;
  logic [BIN_W-1:0]        m_hit;
  logic                    m_taken;
  logic [CNT_W-1:0]        m_cnt;
  logic signed [SUM_W-1:0] m_val;
  logic                    m_cnt_we;
  logic [CNT_W-1:0]        m_cnt_wd;
  logic                    m_val_we;
  logic signed [SUM_W-1:0] m_val_wd;

  shs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  shs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff),
    .divisor_i  (cfg.bin_width),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.bin_hit        = out_hit_q;
  assign out_o.sample_taken   = out_taken_q;
  assign out_o.bin_count_out  = out_cnt_q;
  assign out_o.slot_value_out = out_val_q;

  assign diff         = smp_q - cfg.range_min;
  assign out_of_range = ($signed(smp_q) < $signed(cfg.range_min)) ||
                        ($signed(smp_q) > $signed(cfg.range_max));
  assign div_start    = (state_q == S_RANGE) && !out_of_range && (cfg.bin_width != '0);
  assign q_bin        = (quot > VAL_W'(cfg.last_bin)) ? cfg.last_bin : quot[BIN_W-1:0];

  assign cnt_inc = (rd_cnt_q == '1) ? rd_cnt_q : rd_cnt_q + CNT_W'(1);
  assign smp_ext = SUM_W'(smp_q);
  assign sum_ext = {rd_val_q[SUM_W-1], rd_val_q} + {smp_ext[SUM_W-1], smp_ext};
  assign sum_sat = (sum_ext[SUM_W] != sum_ext[SUM_W-1]) ?
                   {sum_ext[SUM_W], {(SUM_W-1){!sum_ext[SUM_W]}}} : sum_ext[SUM_W-1:0];
  assign first   = (rd_cnt_q == '0);

  always_comb begin
    m_hit    = '0;
    m_taken  = 1'b0;
    m_cnt    = '0;
    m_val    = '0;
    m_cnt_we = 1'b0;
    m_cnt_wd = cnt_inc;
    m_val_we = 1'b0;
    m_val_wd = smp_ext;
    if (cmd_q == CMD_READ) begin
      m_hit = rbin_q;
      if (slot_ok_q) begin
        m_cnt = rbin_ok_q ? rd_cnt_q : '0;
        m_val = rd_val_q;
      end
    end else begin
      m_taken = 1'b1;
      m_hit   = bin_q;
      unique case (cfg.mode)
        MODE_DIST: begin
          m_cnt_we = 1'b1;
          m_cnt    = cnt_inc;
          m_val    = rd_val_q;
        end
        MODE_AVG: begin
          m_cnt_we = 1'b1;
          m_cnt    = cnt_inc;
          m_val_we = 1'b1;
          m_val_wd = sum_sat;
          m_val    = sum_sat;
        end
        MODE_MAX, MODE_MIN: begin
          m_cnt_wd = CNT_W'(1);
          if (first) begin
            m_cnt_we = 1'b1;
            m_val_we = 1'b1;
            m_cnt    = CNT_W'(1);
            m_val    = smp_ext;
          end else begin
            m_cnt = rd_cnt_q;
            if ((cfg.mode == MODE_MAX) ? (smp_ext > rd_val_q) : (smp_ext < rd_val_q)) begin
              m_val_we = 1'b1;
              m_val    = smp_ext;
            end else begin
              m_val    = rd_val_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
      val_we    = (32'(clr_q) < SLOTS);
      val_waddr = clr_q[SLOT_AW-1:0];
      val_wdata = '0;
    end else begin
      cnt_we    = (state_q == S_MODIFY) && m_cnt_we;
      cnt_waddr = addr_q;
      cnt_wdata = m_cnt_wd;
      val_we    = (state_q == S_MODIFY) && m_val_we;
      val_waddr = SLOT_AW'(slot_q);
      val_wdata = m_val_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    rd_cnt_q <= cnt_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    rd_val_q <= val_mem[SLOT_AW'(slot_q)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cmd_q       <= CMD_ADD;
      smp_q       <= '0;
      slot_q      <= '0;
      rbin_q      <= '0;
      slot_ok_q   <= 1'b0;
      rbin_ok_q   <= 1'b0;
      bin_q       <= '0;
      addr_q      <= '0;
      res_hit_q   <= '0;
      res_taken_q <= 1'b0;
      res_cnt_q   <= '0;
      res_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_hit_q   <= '0;
      out_taken_q <= 1'b0;
      out_cnt_q   <= '0;
      out_val_q   <= '0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CNT_AW'(1);
          if (32'(clr_q) == SLOTS * BINS - 1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q       <= in_i.cmd;
            smp_q       <= in_i.sample_value;
            slot_q      <= in_i.time_slot;
            rbin_q      <= in_i.read_bin;
            slot_ok_q   <= (32'(in_i.time_slot) < SLOTS);
            rbin_ok_q   <= (32'(in_i.read_bin) < BINS);
            bin_q       <= '0;
            res_hit_q   <= '0;
            res_taken_q <= 1'b0;
            res_cnt_q   <= '0;
            res_val_q   <= '0;
            if (in_i.cmd == CMD_READ) begin
              addr_q  <= CNT_AW'(in_i.time_slot) * CNT_AW'(BINS) + CNT_AW'(in_i.read_bin);
              state_q <= S_RDREQ;
            end else if (32'(in_i.time_slot) >= SLOTS) begin
              state_q <= S_DONE;
            end else begin
              addr_q  <= CNT_AW'(in_i.time_slot) * CNT_AW'(BINS);
              state_q <= (cfg.mode == MODE_DIST) ? S_RANGE : S_RDREQ;
            end
          end
        end
        S_RANGE: begin
          if (out_of_range) begin
            state_q <= S_DONE;
          end else if (cfg.bin_width == '0) begin
            bin_q   <= cfg.last_bin;
            addr_q  <= addr_q + CNT_AW'(cfg.last_bin);
            state_q <= S_RDREQ;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            bin_q   <= q_bin;
            addr_q  <= addr_q + CNT_AW'(q_bin);
            state_q <= S_RDREQ;
          end
        end
        S_RDREQ: begin
          state_q <= S_MODIFY;
        end
        S_MODIFY: begin
          res_hit_q   <= m_hit;
          res_taken_q <= m_taken;
          res_cnt_q   <= m_cnt;
          res_val_q   <= m_val;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= res_hit_q;
            out_taken_q <= res_taken_q;
            out_cnt_q   <= res_cnt_q;
            out_val_q   <= res_val_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !out_valid_q) else $error("result during clearing pass");
  a_taken_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_taken_q) |-> (out_cnt_q != '0))
    else $error("taken sample with zero bin count");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("second transaction taken");

endmodule

/* bench/shs_checker.sv */
`timescale 1ns / 1ps

module shs_checker
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  shs_in_if           in_mon,
  shs_out_if          out_mon,
  shs_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             taken;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] value;
  } hist_result_t;

  mode_e                   mode_q;
  logic signed [VAL_W-1:0] lo_q;
  logic signed [VAL_W-1:0] hi_q;
  logic [WID_W-1:0]        width_q;
  logic [NBIN_W-1:0]       bins_q;
  logic [CNT_W-1:0]        counts[SLOTS*BINS];
  logic signed [SUM_W-1:0] slot_sums[SLOTS];
  hist_result_t            due_results[$];

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [VAL_W-1:0] v);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W+1-VAL_W){v[VAL_W-1]}}, v};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic hist_result_t hist_predict(cmd_e c, logic signed [VAL_W-1:0] v,
                                                logic [SLOT_W-1:0] s, logic [BIN_W-1:0] rb);
    hist_result_t     r;
    int unsigned      base;
    logic [63:0]      diff;
    logic [63:0]      q;
    logic [63:0]      last;
    logic [BIN_W-1:0] b;
    r = '0;
    b = '0;
    base = s * BINS;
    if (c == CMD_READ) begin
      r.bin = rb;
      r.count = counts[base + rb];
      r.value = slot_sums[s];
      return r;
    end
    r.taken = 1'b1;
    case (mode_q)
      MODE_DIST: begin
        if (v < lo_q || v > hi_q) begin
          r.taken = 1'b0;
        end else begin
          diff = {{(64-VAL_W){v[VAL_W-1]}}, v} - {{(64-VAL_W){lo_q[VAL_W-1]}}, lo_q};
          if (bins_q == '0) begin
            last = 64'd0;
          end else if (bins_q > NBIN_W'(BINS)) begin
            last = 64'(BINS - 1);
          end else begin
            last = 64'(bins_q - 1'b1);
          end
          q = (width_q == '0) ? last : diff / 64'(width_q);
          if (q > last) begin
            q = last;
          end
          b = q[BIN_W-1:0];
          counts[base + b] = bump(counts[base + b]);
        end
      end
      MODE_AVG: begin
        slot_sums[s] = sat_sum(slot_sums[s], v);
        counts[base] = bump(counts[base]);
      end
      MODE_MAX: begin
        if (counts[base] == '0) begin
          slot_sums[s] = v;
          counts[base] = 1;
        end else if (v > slot_sums[s]) begin
          slot_sums[s] = v;
        end
      end
      default: begin
        if (counts[base] == '0) begin
          slot_sums[s] = v;
          counts[base] = 1;
        end else if (v < slot_sums[s]) begin
          slot_sums[s] = v;
        end
      end
    endcase
    if (r.taken) begin
      r.bin = b;
      r.count = counts[base + b];
      r.value = slot_sums[s];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t got;
    hist_result_t want;
    if (!rst_ni) begin
      mode_q = MODE_DIST;
      lo_q = RST_RANGE_MIN;
      hi_q = RST_RANGE_MAX;
      width_q = RST_BIN_WIDTH;
      bins_q = RST_BINS;
      foreach (counts[i]) counts[i] = '0;
      foreach (slot_sums[i]) slot_sums[i] = '0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_RESULT_MODE: mode_q = mode_e'(cfg_mon.data[MODE_W-1:0]);
          REG_RANGE_MIN:   lo_q = cfg_mon.data[VAL_W-1:0];
          REG_RANGE_MAX:   hi_q = cfg_mon.data[VAL_W-1:0];
          REG_BIN_WIDTH:   width_q = cfg_mon.data[WID_W-1:0];
          REG_BINS_IN_USE: bins_q = cfg_mon.data[NBIN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.bin = out_mon.bin_hit;
        got.taken = out_mon.sample_taken;
        got.count = out_mon.bin_count_out;
        got.value = out_mon.slot_value_out;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result transaction with nothing outstanding", $time);
          end
        end else begin
          want = due_results.pop_front();
          if (got.bin !== want.bin || got.taken !== want.taken ||
              got.count !== want.count || got.value !== want.value) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch exp/act bin %0d/%0d taken %0b/%0b", $time,
                       want.bin, got.bin, want.taken, got.taken);
              $display("  count %0d/%0d value %0d/%0d", want.count, got.count,
                       $signed(want.value), $signed(got.value));
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        due_results.insert(due_results.size(),
                           hist_predict(cmd_e'(in_mon.cmd), in_mon.sample_value,
                                        in_mon.time_slot, in_mon.read_bin));
      end
    end
    pending_count = due_results.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import shs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int SAT_ROUNDS = 20;
  localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;

  logic signed [VAL_W-1:0] st_lo;
  logic signed [VAL_W-1:0] st_hi;
  int st_bins;
  int burst_left = 0;
  int rx_left = 0;
  int rx_style = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  shs_in_if  in_if ();
  shs_out_if out_if ();
  shs_cfg_if cfg_if ();

  slotted_histogram_stats_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  shs_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .cfg_mon       (cfg_if),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL slotted_histogram_stats_unit");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rx_steady) begin
      out_if.ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(2);
        rx_left = $urandom_range(4, 80);
      end
      rx_left--;
      case (rx_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(1));
        default: out_if.ready <= ($urandom_range(5) == 0);
      endcase
    end
  end

  task automatic send(cmd_e c, logic [VAL_W-1:0] v, logic [SLOT_W-1:0] s,
                      logic [BIN_W-1:0] b);
    in_if.valid <= 1'b1;
    in_if.cmd <= c;
    in_if.sample_value <= v;
    in_if.time_slot <= s;
    in_if.read_bin <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        in_if.valid <= 1'b0;
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 70)) @(negedge clk_i);
        end else begin
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the sender until every outstanding result has come back
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CFG_DW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_RANGE_MIN: st_lo = d[VAL_W-1:0];
      REG_RANGE_MAX: st_hi = d[VAL_W-1:0];
      REG_BINS_IN_USE: begin
        if (d[NBIN_W-1:0] == '0) begin
          st_bins = 1;
        end else if (d[NBIN_W-1:0] > BINS) begin
          st_bins = BINS;
        end else begin
          st_bins = int'(d[NBIN_W-1:0]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic pick_setup(mode_e m);
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] z;
    logic signed [VAL_W-1:0] t;
    logic [63:0] span;
    logic [63:0] q;
    logic [WID_W-1:0] w;
    logic [NBIN_W-1:0] n;
    int used;
    case ($urandom_range(3))
      0: begin
        a = '0 - VAL_W'($urandom_range(1 << 20));
        z = VAL_W'($urandom_range(1 << 20));
      end
      1: begin
        a = VMIN;
        z = VMAX;
      end
      default: begin
        a = VAL_W'({$urandom, $urandom});
        z = VAL_W'({$urandom, $urandom});
        if (a > z && $urandom_range(7) != 0) begin
          t = a;
          a = z;
          z = t;
        end
      end
    endcase
    case ($urandom_range(5))
      0: n = 7'd1;
      1: n = 7'd64;
      2: n = 7'd0;
      3: n = 7'd127;
      default: n = NBIN_W'($urandom_range(2, BINS));
    endcase
    used = (n == '0) ? 1 : (n > BINS) ? BINS : int'(n);
    span = (a <= z) ? ({{16{z[VAL_W-1]}}, z} - {{16{a[VAL_W-1]}}, a}) : 64'd65536;
    q = span / 64'(used);
    case ($urandom_range(9))
      0: w = '0;
      1: w = WID_W'(1);
      2: w = '1;
      default: w = (q >= 64'h7FFF_FFFF_FFFF) ? '1 : WID_W'(q + 64'($urandom_range(2)));
    endcase
    set_reg(REG_RESULT_MODE, CFG_DW'(m));
    set_reg(REG_RANGE_MIN, a);
    set_reg(REG_RANGE_MAX, z);
    set_reg(REG_BIN_WIDTH, CFG_DW'(w));
    set_reg(REG_BINS_IN_USE, CFG_DW'(n));
  endtask

  task automatic random_txn();
    logic [63:0] span;
    logic [63:0] off;
    logic [VAL_W-1:0] v;
    logic [SLOT_W-1:0] s;
    logic [BIN_W-1:0] b;
    cmd_e c;
    c = ($urandom_range(9) < 3) ? CMD_READ : CMD_ADD;
    s = ($urandom_range(9) < 7) ? SLOT_W'($urandom_range(7)) : SLOT_W'($urandom_range(63));
    b = ($urandom_range(4) != 0) ? BIN_W'($urandom_range(st_bins - 1))
                                 : BIN_W'($urandom_range(63));
    case ($urandom_range(7))
      0: v = VAL_W'({$urandom, $urandom});
      1: begin
        case ($urandom_range(6))
          0: v = VMAX;
          1: v = VMIN;
          2: v = st_lo;
          3: v = st_hi;
          4: v = st_lo - 1'b1;
          5: v = st_hi + 1'b1;
          default: v = '0;
        endcase
      end
      default: begin
        if (st_lo <= st_hi) begin
          span = {{16{st_hi[VAL_W-1]}}, st_hi} - {{16{st_lo[VAL_W-1]}}, st_lo};
          off = {$urandom, $urandom} % (span + 1);
          v = st_lo + off[VAL_W-1:0];
        end else begin
          v = VAL_W'({$urandom, $urandom});
        end
      end
    endcase
    send(c, v, s, b);
  endtask

  initial begin
    mode_e m;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_ADD;
    in_if.sample_value = '0;
    in_if.time_slot = '0;
    in_if.read_bin = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_RESULT_MODE;
    cfg_if.data = '0;
    st_lo = RST_RANGE_MIN;
    st_hi = RST_RANGE_MAX;
    st_bins = RST_BINS;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: range edges, out of range, highest slot
    send(CMD_ADD, VAL_W'(0), 6'd0, 6'd0);
    send(CMD_ADD, VAL_W'(65536), 6'd0, 6'd0);
    send(CMD_ADD, VAL_W'(-1), 6'd0, 6'd0);
    send(CMD_ADD, VAL_W'(65537), 6'd0, 6'd0);
    send(CMD_ADD, VAL_W'(32768), 6'd63, 6'd0);
    send(CMD_READ, VMAX, 6'd0, 6'd9);
    send(CMD_READ, '0, 6'd63, 6'd63);

    // full range, zero bin width, zero bins
    settle();
    set_reg(REG_RANGE_MIN, VMIN);
    set_reg(REG_RANGE_MAX, VMAX);
    set_reg(REG_BIN_WIDTH, '0);
    set_reg(REG_BINS_IN_USE, '0);
    send(CMD_ADD, VMIN, 6'd1, 6'd0);
    send(CMD_ADD, VMAX, 6'd1, 6'd0);

    settle();
    set_reg(REG_BIN_WIDTH, CFG_DW'({WID_W{1'b1}}));
    set_reg(REG_BINS_IN_USE, CFG_DW'(7'd127));
    send(CMD_ADD, VMAX, 6'd1, 6'd0);
    send(CMD_ADD, VMIN, 6'd1, 6'd0);

    settle();
    set_reg(REG_BIN_WIDTH, CFG_DW'(1));
    set_reg(REG_BINS_IN_USE, CFG_DW'(BINS));
    send(CMD_ADD, VMAX, 6'd62, 6'd0);
    send(CMD_READ, '0, 6'd62, 6'd63);

    // inverted range drops every sample
    settle();
    set_reg(REG_RANGE_MIN, CFG_DW'(1000));
    set_reg(REG_RANGE_MAX, VAL_W'(-1000));
    send(CMD_ADD, '0, 6'd5, 6'd0);

    settle();
    set_reg(REG_RESULT_MODE, CFG_DW'(MODE_AVG));
    send(CMD_ADD, VMAX, 6'd0, 6'd0);
    send(CMD_ADD, VMIN, 6'd0, 6'd0);
    send(CMD_READ, '0, 6'd0, 6'd0);

    settle();
    set_reg(REG_RESULT_MODE, CFG_DW'(MODE_MAX));
    send(CMD_ADD, VAL_W'(-5), 6'd7, 6'd0);
    send(CMD_ADD, VAL_W'(-9), 6'd7, 6'd0);
    send(CMD_ADD, VAL_W'(100), 6'd7, 6'd0);

    settle();
    set_reg(REG_RESULT_MODE, CFG_DW'(MODE_MIN));
    send(CMD_ADD, VAL_W'(50), 6'd8, 6'd0);
    send(CMD_ADD, VAL_W'(60), 6'd8, 6'd0);
    send(CMD_ADD, VMIN, 6'd8, 6'd0);
    send(CMD_READ, '0, 6'd8, 6'd3);

    // drive two average sums back to back toward both limits
    settle();
    set_reg(REG_RESULT_MODE, CFG_DW'(MODE_AVG));
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < SAT_ROUNDS; i++) begin
      send(CMD_ADD, VMAX, 6'd3, 6'd0);
      send(CMD_ADD, VMIN, 6'd4, 6'd0);
    end
    send(CMD_READ, '0, 6'd3, 6'd0);
    send(CMD_READ, '0, 6'd4, 6'd0);
    settle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    for (int p = 0; p < 7; p++) begin
      case (p)
        0, 2, 4: m = MODE_DIST;
        1: m = MODE_AVG;
        3: m = MODE_MAX;
        5: m = MODE_MIN;
        default: m = mode_e'($urandom_range(3));
      endcase
      settle();
      pick_setup(m);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == ITEMS_PER_PHASE / 2) begin
          settle();
        end
        random_txn();
      end
    end

    settle();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS slotted_histogram_stats_unit");
    end else begin
      $display("FAIL slotted_histogram_stats_unit");
    end
    $finish;
  end

endmodule
